[sv/apmr_pkg.sv]
package apmr_pkg;

  // frame and result field widths
  localparam int FIELD_W    = 24;
  localparam int VAL_W      = 32;
  localparam int PF_W       = 17;

  // shared serial datapath
  localparam int ACC_W      = 56;
  localparam int MUL_B_W    = 32;
  localparam int MUL_STEPS  = 32;
  localparam int DIV_STEPS  = 56;
  localparam int CNT_W      = 6;

  // stream and configuration payloads
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 152;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [VAL_W-1:0]   MAX32       = 32'hFFFF_FFFF;
  localparam logic [PF_W-1:0]    MAX_PF      = 17'h1_FFFF;
  localparam logic [FIELD_W-1:0] COEF_RESET  = 24'h01_0000;
  localparam logic [MUL_B_W-1:0] UNITY_SCALE = 32'h0001_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_COEF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_CALIBRATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_REF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_REF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_REF       = 3'd5;

  // sequencer steps of one measure item
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_V_MUL   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_V_DIV   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_I_MUL   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_I_DIV   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_P_MUL   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_P_SCALE = 4'd5;
  localparam logic [STEP_W-1:0] STEP_P_DIV   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_S_MUL   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PF_DIV  = 4'd8;

endpackage

[sv/ac_power_meter_readout.sv]
// AC power meter readout
//
// Input stream: one decoded meter frame per transfer. in_tuser is the op bit
// (0 measure, 1 capture calibration periods), in_tdata the six 24-bit words.
// Output stream: one result per measure frame, nothing for a capture frame.
// Configuration: cfg_valid/cfg_ready write channel, always ready, one
// register per transfer; writes are expected only while the block is idle.
//
// A capture frame only stores its three periods. A measure frame runs nine
// steps on one shared bit-serial unit: five shift-add multiplies and four
// restoring divides, each step opened by a setup state, and the result is
// registered once the last divide has ended and the output register is free.
// The sequencer handles one frame at a time; in_tready is high only while it
// idles, so no measure frame is taken before the sequencer is through with the last.
// The result sits in an output register: the next frame is taken while it
// waits, and a stalled receiver only holds the sequencer at its last step.
// Synchronous reset clears the sequencer, the output valid, the captured
// periods and the configuration registers to their defaults.
module ac_power_meter_readout (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // voltage_param, voltage_period, current_param, current_period,
  // power_param, power_period
  input  logic [apmr_pkg::IN_DATA_W-1:0]    in_tdata,
  // op
  input  logic                              in_tuser,
  // output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // voltage, current, active_power, apparent_power, power_factor, zero pad
  output logic [apmr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // zero_divisor
  output logic                              out_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apmr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apmr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import apmr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // configuration and captured periods
  logic [FIELD_W-1:0] vcoef_r, icoef_r;
  logic               use_cal_r;
  logic [VAL_W-1:0]   vref_r, iref_r, pref_r;
  logic [FIELD_W-1:0] cal_v_r, cal_i_r, cal_p_r;

  // frame words
  logic [FIELD_W-1:0] vpar_r, vper_r, ipar_r, iper_r, ppar_r, pper_r;

  // serial unit
  logic [ACC_W-1:0]   hi_r, hi_nxt;
  logic [MUL_B_W-1:0] lo_r, lo_nxt;
  logic [ACC_W-1:0]   mcand_r, mcand_nxt;
  logic [ACC_W-1:0]   num_r, num_nxt;
  logic [VAL_W-1:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0]   den_r, den_nxt;
  logic [VAL_W-1:0]   q_r, q_nxt;
  logic               over_r, over_nxt;

  // intermediate results
  logic [VAL_W-1:0]   v_r, v_nxt, i_r, i_nxt, p_r, p_nxt, s_r, s_nxt;
  logic [PF_W-1:0]    pf_r, pf_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic               out_zero_r, out_zero_nxt;

  logic               in_xfer;
  logic               step_is_mul;
  logic [ACC_W-1:0]   op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [ACC_W-1:0]   op_num;
  logic [VAL_W-1:0]   op_den;
  logic [VAL_W-1:0]   s_sat;
  logic [ACC_W:0]     mul_sum;
  logic [VAL_W:0]     rem_sh, rem_diff;
  logic               div_ge;
  logic [VAL_W-1:0]   q_step;
  logic               over_step;
  logic [VAL_W-1:0]   quo32;
  logic [PF_W-1:0]    quo_pf;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  // apparent power from the product register: bits 63..16, saturated
  assign s_sat = (hi_r[31:16] != 16'd0) ? MAX32 : {hi_r[15:0], lo_r[31:16]};

  // operand selection for the step about to start
  always_comb begin
    step_is_mul = 1'b0;
    op_a   = '0;
    op_b   = '0;
    op_num = '0;
    op_den = '0;
    case (step_r)
      STEP_V_MUL: begin
        step_is_mul = 1'b1;
        op_a = use_cal_r ? {24'd0, vref_r} : {32'd0, vpar_r};
        op_b = use_cal_r ? {8'd0, cal_v_r} : {8'd0, vcoef_r};
      end
      STEP_I_MUL: begin
        step_is_mul = 1'b1;
        op_a = use_cal_r ? {24'd0, iref_r} : {32'd0, ipar_r};
        op_b = use_cal_r ? {8'd0, cal_i_r} : {8'd0, icoef_r};
      end
      STEP_P_MUL: begin
        step_is_mul = 1'b1;
        op_a = use_cal_r ? {24'd0, pref_r} : {32'd0, ppar_r};
        op_b = use_cal_r ? {8'd0, cal_p_r} : {8'd0, vcoef_r};
      end
      STEP_P_SCALE: begin
        // second factor of the power numerator; unity in calibrated mode
        step_is_mul = 1'b1;
        op_a = {hi_r[23:0], lo_r};
        op_b = use_cal_r ? UNITY_SCALE : {8'd0, icoef_r};
      end
      STEP_S_MUL: begin
        step_is_mul = 1'b1;
        op_a = {24'd0, v_r};
        op_b = i_r;
      end
      STEP_V_DIV: begin
        op_num = {hi_r[23:0], lo_r};
        op_den = {8'd0, vper_r};
      end
      STEP_I_DIV: begin
        op_num = {hi_r[23:0], lo_r};
        op_den = {8'd0, iper_r};
      end
      STEP_P_DIV: begin
        // dividing by period * 65536 is dropping 16 product bits first
        op_num = {hi_r[39:0], lo_r[31:16]};
        op_den = {8'd0, pper_r};
      end
      STEP_PF_DIV: begin
        op_num = {8'd0, p_r, 16'd0};
        op_den = s_sat;
      end
      default: begin
        step_is_mul = 1'b0;
      end
    endcase
  end

  // one shift-add multiply bit and one restoring divide bit
  always_comb begin
    mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : {(ACC_W+1){1'b0}});
    rem_sh    = {rem_r, num_r[ACC_W-1]};
    rem_diff  = rem_sh - {1'b0, den_r};
    div_ge    = (rem_sh >= {1'b0, den_r});
    q_step    = {q_r[VAL_W-2:0], div_ge};
    over_step = over_r | q_r[VAL_W-1];
    quo32     = over_step ? MAX32 : q_step;
    quo_pf    = (over_step || (q_step[VAL_W-1:PF_W] != '0)) ? MAX_PF : q_step[PF_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    mcand_nxt     = mcand_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    over_nxt      = over_r;
    v_nxt         = v_r;
    i_nxt         = i_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    pf_nxt        = pf_r;
    out_data_nxt  = out_data_r;
    out_zero_nxt  = out_zero_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer && !in_tuser) begin
          state_nxt = S_SETUP;
          step_nxt  = STEP_V_MUL;
        end
      end
      S_SETUP: begin
        cnt_nxt = '0;
        if (step_is_mul) begin
          mcand_nxt = op_a;
          lo_nxt    = op_b;
          hi_nxt    = '0;
          state_nxt = S_MUL;
        end else begin
          num_nxt   = op_num;
          den_nxt   = op_den;
          rem_nxt   = '0;
          q_nxt     = '0;
          over_nxt  = 1'b0;
          state_nxt = S_DIV;
          if (step_r == STEP_PF_DIV) begin
            s_nxt = s_sat;
          end
        end
      end
      S_MUL: begin
        hi_nxt  = mul_sum[ACC_W:1];
        lo_nxt  = {mul_sum[0], lo_r[MUL_B_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_DIV: begin
        num_nxt  = {num_r[ACC_W-2:0], 1'b0};
        rem_nxt  = div_ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        q_nxt    = q_step;
        over_nxt = over_step;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_SETUP;
          case (step_r)
            STEP_V_DIV: v_nxt = quo32;
            STEP_I_DIV: i_nxt = quo32;
            STEP_P_DIV: p_nxt = quo32;
            STEP_PF_DIV: begin
              pf_nxt    = quo_pf;
              state_nxt = S_DONE;
            end
            default: v_nxt = v_r;
          endcase
        end
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, pf_r, s_r, p_r, i_r, v_r};
          out_zero_nxt  = (vper_r == '0) || (iper_r == '0) || (pper_r == '0)
                          || (s_r == '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers, configuration and captured periods
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_V_MUL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      vcoef_r     <= COEF_RESET;
      icoef_r     <= COEF_RESET;
      use_cal_r   <= 1'b0;
      vref_r      <= '0;
      iref_r      <= '0;
      pref_r      <= '0;
      cal_v_r     <= '0;
      cal_i_r     <= '0;
      cal_p_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VOLTAGE_COEF:    vcoef_r   <= cfg_data[FIELD_W-1:0];
          REG_CURRENT_COEF:    icoef_r   <= cfg_data[FIELD_W-1:0];
          REG_USE_CALIBRATION: use_cal_r <= cfg_data[0];
          REG_VOLTAGE_REF:     vref_r    <= cfg_data;
          REG_CURRENT_REF:     iref_r    <= cfg_data;
          REG_POWER_REF:       pref_r    <= cfg_data;
          default:             use_cal_r <= use_cal_r;
        endcase
      end
      if (in_xfer && in_tuser) begin
        cal_v_r <= in_tdata[47:24];
        cal_i_r <= in_tdata[95:72];
        cal_p_r <= in_tdata[143:120];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vpar_r <= in_tdata[23:0];
      vper_r <= in_tdata[47:24];
      ipar_r <= in_tdata[71:48];
      iper_r <= in_tdata[95:72];
      ppar_r <= in_tdata[119:96];
      pper_r <= in_tdata[143:120];
    end
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    mcand_r    <= mcand_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    over_r     <= over_nxt;
    v_r        <= v_nxt;
    i_r        <= i_nxt;
    p_r        <= p_nxt;
    s_r        <= s_nxt;
    pf_r       <= pf_nxt;
    out_data_r <= out_data_nxt;
    out_zero_r <= out_zero_nxt;
  end

  // a measure frame starts the sequence at its first step
  a_measure_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_tuser |=> state_r == S_SETUP && step_r == STEP_V_MUL)
    else $error("measure frame did not start the sequencer");

  // a capture frame stores the voltage and power periods and leaves the sequencer idle
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser |=> state_r == S_IDLE && cal_v_r == $past(in_tdata[47:24])
      && cal_p_r == $past(in_tdata[143:120]))
    else $error("calibration periods not captured");

  // multiply iterations only run on multiply steps
  a_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> (step_r == STEP_V_MUL || step_r == STEP_I_MUL
      || step_r == STEP_P_MUL || step_r == STEP_P_SCALE || step_r == STEP_S_MUL))
    else $error("multiply running on a divide step");

  // a result appears only out of the final state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the final state");

endmodule

[dv/tb.sv]
module tb;
  import apmr_pkg::*;

  localparam logic OP_MEASURE       = 1'b0;
  localparam logic OP_CAPTURE       = 1'b1;
  localparam int   SETTLE_CYCLES    = 450;
  localparam int   CYCLE_LIMIT      = 6_000_000;
  localparam int   RANDOM_PHASES    = 20;
  localparam int   FRAMES_PER_PHASE = 100;
  localparam int   REPORT_LIMIT     = 10;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] voltage_param;
    logic [FIELD_W-1:0] voltage_period;
    logic [FIELD_W-1:0] current_param;
    logic [FIELD_W-1:0] current_period;
    logic [FIELD_W-1:0] power_param;
    logic [FIELD_W-1:0] power_period;
  } frame_t;

  typedef struct packed {
    logic [VAL_W-1:0] voltage;
    logic [VAL_W-1:0] current;
    logic [VAL_W-1:0] active_power;
    logic [VAL_W-1:0] apparent_power;
    logic [PF_W-1:0]  power_factor;
    logic             zero_divisor;
  } reading_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_value;
    frame_t                frame;
    logic                  known;
    reading_t              reading;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // settings and captured periods as the block should hold them
  logic [FIELD_W-1:0] vscale = COEF_RESET;
  logic [FIELD_W-1:0] iscale = COEF_RESET;
  logic               cal_mode = 1'b0;
  logic [VAL_W-1:0]   vref = '0;
  logic [VAL_W-1:0]   iref = '0;
  logic [VAL_W-1:0]   pref = '0;
  logic [FIELD_W-1:0] held_vper = '0;
  logic [FIELD_W-1:0] held_iper = '0;
  logic [FIELD_W-1:0] held_pper = '0;

  reading_t    pending_readings[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;

  ac_power_meter_readout dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // quotient clamped to 32 bits, zero divisor saturates and flags
  function automatic logic [VAL_W-1:0] clamp_quotient(input logic [127:0] num,
                                                      input logic [127:0] den,
                                                      inout logic zero);
    logic [127:0] q;
    if (den == 0) begin
      zero = 1'b1;
      return MAX32;
    end
    q = num / den;
    return (q > 128'(MAX32)) ? MAX32 : q[VAL_W-1:0];
  endfunction

  // expected reading of one frame; a capture frame only updates the held periods
  function automatic logic predict_reading(input frame_t f, output reading_t r);
    logic         zero;
    logic [127:0] prod;
    logic [127:0] ratio;
    r = '0;
    zero = 1'b0;
    if (f.op == OP_CAPTURE) begin
      held_vper = f.voltage_period;
      held_iper = f.current_period;
      held_pper = f.power_period;
      return 1'b0;
    end
    if (cal_mode) begin
      r.voltage = clamp_quotient(128'(vref) * 128'(held_vper), 128'(f.voltage_period), zero);
      r.current = clamp_quotient(128'(iref) * 128'(held_iper), 128'(f.current_period), zero);
      r.active_power = clamp_quotient(128'(pref) * 128'(held_pper), 128'(f.power_period),
                                      zero);
    end else begin
      r.voltage = clamp_quotient(128'(f.voltage_param) * 128'(vscale),
                                 128'(f.voltage_period), zero);
      r.current = clamp_quotient(128'(f.current_param) * 128'(iscale),
                                 128'(f.current_period), zero);
      r.active_power = clamp_quotient(128'(f.power_param) * 128'(vscale) * 128'(iscale),
                                      128'(f.power_period) << 16, zero);
    end
    prod = (128'(r.voltage) * 128'(r.current)) >> 16;
    r.apparent_power = (prod > 128'(MAX32)) ? MAX32 : prod[VAL_W-1:0];
    if (r.apparent_power == 0) begin
      zero = 1'b1;
      r.power_factor = MAX_PF;
    end else begin
      ratio = (128'(r.active_power) << 16) / 128'(r.apparent_power);
      r.power_factor = (ratio > 128'(MAX_PF)) ? MAX_PF : ratio[PF_W-1:0];
    end
    r.zero_divisor = zero;
    return 1'b1;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_VOLTAGE_COEF:    vscale = value[FIELD_W-1:0];
      REG_CURRENT_COEF:    iscale = value[FIELD_W-1:0];
      REG_USE_CALIBRATION: cal_mode = value[0];
      REG_VOLTAGE_REF:     vref = value;
      REG_CURRENT_REF:     iref = value;
      REG_POWER_REF:       pref = value;
      default: ;
    endcase
  endfunction

  // directed table rows
  function automatic stim_row_t frame_row(input logic op,
                                          input logic [FIELD_W-1:0] vpar, vper,
                                          input logic [FIELD_W-1:0] ipar, iper,
                                          input logic [FIELD_W-1:0] ppar, pper);
    stim_row_t row;
    row = '0;
    row.kind = ROW_FRAME;
    row.frame = '{op, vpar, vper, ipar, iper, ppar, pper};
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [FIELD_W-1:0] vpar, vper,
                                          input logic [FIELD_W-1:0] ipar, iper,
                                          input logic [FIELD_W-1:0] ppar, pper,
                                          input reading_t r);
    stim_row_t row;
    row = frame_row(OP_MEASURE, vpar, vper, ipar, iper, ppar, pper);
    row.known = 1'b1;
    row.reading = r;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_index = idx;
    row.cfg_value = value;
    return row;
  endfunction

  // frame word biased toward zero, all ones, one and small values
  function automatic logic [FIELD_W-1:0] rand_word(input int zero_pct);
    int          sel;
    logic [31:0] raw;
    sel = $urandom_range(99);
    raw = $urandom;
    if (sel < zero_pct) return '0;
    if (sel < zero_pct + 5) return '1;
    if (sel < zero_pct + 10) return 24'd1;
    if (sel < 45) return {12'd0, raw[11:0]};
    return raw[FIELD_W-1:0];
  endfunction

  function automatic frame_t random_frame(input logic op);
    frame_t f;
    f.op = op;
    f.voltage_param = rand_word(5);
    f.voltage_period = rand_word(3);
    f.current_param = rand_word(5);
    f.current_period = rand_word(3);
    f.power_param = rand_word(5);
    f.power_period = rand_word(3);
    return f;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_coef();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return COEF_RESET;
      3: return {6'd0, raw[17:0]};
      default: return raw[FIELD_W-1:0];
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_ref();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(7))
      0: return '0;
      1: return MAX32;
      2: return UNITY_SCALE;
      3: return {8'd0, raw[23:0]};
      default: return raw;
    endcase
  endfunction

  // one register write transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every pending reading, then let a capture frame settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one frame transfer, sometimes with a random gap in front
  task automatic send_frame(input frame_t f, input logic known, input reading_t known_reading);
    reading_t predicted;
    int       pick;
    pick = $urandom_range(99);
    if (!calm && pick < 35) begin
      in_tvalid <= 1'b0;
      if (pick < 8) repeat ($urandom_range(1, SETTLE_CYCLES)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end else if (!calm && pick == 35) begin
      // hold off until every pending reading has arrived
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_readings.size() != 0) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f.op;
    in_tdata <= {f.power_period, f.power_param, f.current_period, f.current_param,
                 f.voltage_period, f.voltage_param};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_reading(f, predicted))
      pending_readings.push_back(known ? known_reading : predicted);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 35);
  end

  // compare each result transfer with the oldest pending reading
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
              out_tdata[144:128], out_tuser};
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("reading with none pending: v=%h i=%h p=%h s=%h pf=%h z=%b",
                   got.voltage, got.current, got.active_power, got.apparent_power,
                   got.power_factor, got.zero_divisor);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("reading mismatch exp: v=%h i=%h p=%h s=%h pf=%h z=%b",
                     want.voltage, want.current, want.active_power, want.apparent_power,
                     want.power_factor, want.zero_divisor);
            $display("                 got: v=%h i=%h p=%h s=%h pf=%h z=%b",
                     got.voltage, got.current, got.active_power, got.apparent_power,
                     got.power_factor, got.zero_divisor);
          end
        end
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ac_power_meter_readout test failed");
      $finish;
    end
  end

  initial begin
    logic               last_was_frame;
    logic [FIELD_W-1:0] new_vscale, new_iscale;
    logic [VAL_W-1:0]   new_vref, new_iref, new_pref;
    logic               new_mode;
    logic [31:0]        noise;
    logic               capture;

    // ratio mode with reset coefficients: extremes and zero periods
    directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0,
                            reading_t'{MAX32, MAX32, MAX32, MAX32, 17'h1_0000, 1'b1}));
    directed_rows.push_back(known_row(0, 1, 0, 1, 0, 1,
                            reading_t'{32'd0, 32'd0, 32'd0, 32'd0, MAX_PF, 1'b1}));
    directed_rows.push_back(known_row('1, 1, '1, 1, '1, 1,
                            reading_t'{MAX32, MAX32, MAX32, MAX32, 17'h1_0000, 1'b0}));
    directed_rows.push_back(known_row('1, '1, '1, '1, '1, '1,
                            reading_t'{UNITY_SCALE, UNITY_SCALE, UNITY_SCALE, UNITY_SCALE,
                                       17'h1_0000, 1'b0}));
    directed_rows.push_back(known_row(1, '1, 1, '1, 1, '1,
                            reading_t'{32'd0, 32'd0, 32'd0, 32'd0, MAX_PF, 1'b1}));
    // one period zero at a time
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h00E600, 24'h000000, 24'h000500,
                                      24'h000100, 24'h001000, 24'h000200));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h001000, 24'h000100, 24'h002000,
                                      24'h000000, 24'h000800, 24'h000100));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h003000, 24'h000200, 24'h000400,
                                      24'h000100, 24'h000800, 24'h000000));
    // ordinary frame, then active power far above apparent power
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h0A5A5A, 24'h05A5A5, 24'h123456,
                                      24'h654321, 24'h3C3C3C, 24'h0F0F0F));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h000001, 24'h000010, 24'h000001,
                                      24'h000010, 24'hFFFFFF, 24'h000001));
    // capture in ratio mode leaves measure frames unchanged
    directed_rows.push_back(frame_row(OP_CAPTURE, 24'hA5A5A5, 24'h000100, 24'hA5A5A5,
                                      24'h000200, 24'hA5A5A5, 24'h000400));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h001234, 24'h000100, 24'h004321,
                                      24'h000200, 24'h00ABCD, 24'h000400));
    // calibrated mode with zero references
    directed_rows.push_back(cfg_row(REG_USE_CALIBRATION, 32'd1));
    directed_rows.push_back(known_row(24'hA5A5A5, 24'h000100, 24'hA5A5A5, 24'h000200,
                            24'hA5A5A5, 24'h000400,
                            reading_t'{32'd0, 32'd0, 32'd0, 32'd0, MAX_PF, 1'b1}));
    // full scale references
    directed_rows.push_back(cfg_row(REG_VOLTAGE_REF, MAX32));
    directed_rows.push_back(cfg_row(REG_CURRENT_REF, MAX32));
    directed_rows.push_back(cfg_row(REG_POWER_REF, MAX32));
    directed_rows.push_back(known_row(24'hA5A5A5, 24'h000100, 24'hA5A5A5, 24'h000200,
                            24'hA5A5A5, 24'h000400,
                            reading_t'{MAX32, MAX32, MAX32, MAX32, 17'h1_0000, 1'b0}));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h5A5A5A, 24'hFFFFFF, 24'h5A5A5A,
                                      24'hFFFFFF, 24'h5A5A5A, 24'hFFFFFF));
    directed_rows.push_back(known_row(24'hA5A5A5, 0, 24'hA5A5A5, 0, 24'hA5A5A5, 0,
                            reading_t'{MAX32, MAX32, MAX32, MAX32, 17'h1_0000, 1'b1}));
    // zero captured periods give zero readings
    directed_rows.push_back(frame_row(OP_CAPTURE, 24'hA5A5A5, 0, 24'hA5A5A5, 0,
                                      24'hA5A5A5, 0));
    directed_rows.push_back(known_row(24'hA5A5A5, 24'h000010, 24'hA5A5A5, 24'h000020,
                            24'hA5A5A5, 24'h000030,
                            reading_t'{32'd0, 32'd0, 32'd0, 32'd0, MAX_PF, 1'b1}));
    // moderate references and extreme coefficients
    directed_rows.push_back(cfg_row(REG_VOLTAGE_REF, 32'h0001_0000));
    directed_rows.push_back(cfg_row(REG_CURRENT_REF, 32'h0002_8000));
    directed_rows.push_back(cfg_row(REG_POWER_REF, 32'h0000_C000));
    directed_rows.push_back(cfg_row(REG_VOLTAGE_COEF, 32'h00FF_FFFF));
    directed_rows.push_back(cfg_row(REG_CURRENT_COEF, 32'd0));
    directed_rows.push_back(frame_row(OP_CAPTURE, 24'h111111, 24'h001000, 24'h222222,
                                      24'h000800, 24'h333333, 24'h000C00));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'h444444, 24'h000FF0, 24'h555555,
                                      24'h000801, 24'h666666, 24'h000BFF));
    // back to ratio mode with those coefficients
    directed_rows.push_back(cfg_row(REG_USE_CALIBRATION, 32'd0));
    directed_rows.push_back(frame_row(OP_MEASURE, 24'hFFFFFF, 24'h000100, 24'h123456,
                                      24'h000100, 24'h00FFFF, 24'h000100));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    last_was_frame = 1'b0;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        if (last_was_frame) drain();
        write_reg(directed_rows[k].cfg_index, directed_rows[k].cfg_value);
        last_was_frame = 1'b0;
      end else begin
        send_frame(directed_rows[k].frame, directed_rows[k].known, directed_rows[k].reading);
        last_was_frame = 1'b1;
      end
    end

    // random phases, each with its own register settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      calm = (phase == 5) || (phase == 6);
      case (phase)
        0, 1: begin
          new_vscale = '1;
          new_iscale = '1;
          new_vref = MAX32;
          new_iref = MAX32;
          new_pref = MAX32;
          new_mode = (phase == 1);
        end
        2, 3: begin
          new_vscale = '0;
          new_iscale = '0;
          new_vref = '0;
          new_iref = '0;
          new_pref = '0;
          new_mode = (phase == 3);
        end
        default: begin
          new_vscale = pick_coef();
          new_iscale = pick_coef();
          new_vref = pick_ref();
          new_iref = pick_ref();
          new_pref = pick_ref();
          new_mode = 1'($urandom_range(1));
        end
      endcase
      // unused upper data bits carry noise
      noise = $urandom;
      write_reg(REG_VOLTAGE_COEF, {noise[7:0], new_vscale});
      write_reg(REG_CURRENT_COEF, {noise[15:8], new_iscale});
      write_reg(REG_USE_CALIBRATION, {noise[31:1], new_mode});
      write_reg(REG_VOLTAGE_REF, new_vref);
      write_reg(REG_CURRENT_REF, new_iref);
      write_reg(REG_POWER_REF, new_pref);
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        // calibrated phases open with a capture frame
        capture = (cal_mode && n == 0) || ($urandom_range(9) == 0);
        send_frame(random_frame(capture ? OP_CAPTURE : OP_MEASURE), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ac_power_meter_readout test passed");
    end else begin
      $display("ac_power_meter_readout test failed");
    end
    $finish;
  end

endmodule
